[hw/rtl/qbvg_pkg.sv]
package qbvg_pkg;

   localparam int SLOT_COUNT      = 32;
   localparam int SLOT_W          = $clog2(SLOT_COUNT);
   localparam int USED_W          = SLOT_W + 1;
   localparam int MAX_BATCH_QUADS = 16384;
   localparam int LIMIT_W         = 15;
   localparam int INDEX_W         = 17;
   localparam int QUAD_INDICES    = 6;
   localparam int HANDLE_W        = 16;
   localparam int COORD_W         = 20;
   localparam int ROW_W           = 3 * COORD_W;
   localparam int SUM_W           = COORD_W + 3;
   localparam int COLOR_W         = 32;
   localparam int TILING_W        = 16;
   localparam int ENTITY_W        = 32;

   localparam logic [1:0] CMD_BEGIN = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_BIND   = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_BATCH_QUADS);

   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   addr;
      logic [HANDLE_W-1:0] data;
   } slot_wr_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          corner;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic [COORD_W-1:0]  pos_z;
      logic [COLOR_W-1:0]  vertex_color;
      logic [SLOT_W-1:0]   slot_number;
      logic [HANDLE_W-1:0] bound_handle;
      logic [TILING_W-1:0] vertex_tiling;
      logic [ENTITY_W-1:0] vertex_entity;
      logic [INDEX_W-1:0]  batch_indices;
      logic                last;
   } rsp_payload_type;

endpackage

[hw/rtl/qbvg_if.sv]
interface qbvg_req_if import qbvg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 cmd;
   logic [ROW_W-1:0]           row_x;
   logic [ROW_W-1:0]           row_y;
   logic [ROW_W-1:0]           row_z;
   logic [COLOR_W-1:0]         quad_color;
   logic [HANDLE_W-1:0]        texture_handle;
   logic [TILING_W-1:0]        tiling_factor;
   logic signed [ENTITY_W-1:0] entity_tag;

   modport source (
      output valid, cmd, row_x, row_y, row_z, quad_color, texture_handle,
             tiling_factor, entity_tag,
      input  ready
   );
   modport sink (
      input  valid, cmd, row_x, row_y, row_z, quad_color, texture_handle,
             tiling_factor, entity_tag,
      output ready
   );
endinterface

interface qbvg_rsp_if import qbvg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 kind;
   logic [1:0]                 corner;
   logic signed [COORD_W-1:0]  pos_x;
   logic signed [COORD_W-1:0]  pos_y;
   logic signed [COORD_W-1:0]  pos_z;
   logic [COLOR_W-1:0]         vertex_color;
   logic [SLOT_W-1:0]          slot_number;
   logic [HANDLE_W-1:0]        bound_handle;
   logic [TILING_W-1:0]        vertex_tiling;
   logic signed [ENTITY_W-1:0] vertex_entity;
   logic [INDEX_W-1:0]         batch_indices;
   logic                       last;

   modport source (
      output valid, kind, corner, pos_x, pos_y, pos_z, vertex_color, slot_number,
             bound_handle, vertex_tiling, vertex_entity, batch_indices, last,
      input  ready
   );
   modport sink (
      input  valid, kind, corner, pos_x, pos_y, pos_z, vertex_color, slot_number,
             bound_handle, vertex_tiling, vertex_entity, batch_indices, last,
      output ready
   );
endinterface

[hw/rtl/qbvg_slot_table.sv]
module qbvg_slot_table import qbvg_pkg::*; (
   input  logic                clock,
   input  slot_wr_type         wr,
   input  logic [SLOT_W-1:0]   rd_addr,
   output logic [HANDLE_W-1:0] rd_data_ff
);

   logic [HANDLE_W-1:0] mem [SLOT_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[hw/rtl/qbvg_coord_unit.sv]
module qbvg_coord_unit import qbvg_pkg::*; (
   input  logic               clock,
   input  logic [ROW_W-1:0]   row,
   input  logic [1:0]         corner,
   output logic [COORD_W-1:0] coord_ff
);

   logic signed [SUM_W-1:0] c0_s;
   logic signed [SUM_W-1:0] c1_s;
   logic signed [SUM_W-1:0] c3_s;
   logic signed [SUM_W-1:0] sum_s;
   logic        [SUM_W-2:0] half;
   logic                    sx_pos;
   logic                    sy_pos;
   logic [COORD_W-1:0]      coord_in;

   always_comb begin
      c0_s   = SUM_W'($signed(row[COORD_W-1:0]));
      c1_s   = SUM_W'($signed(row[2*COORD_W-1:COORD_W]));
      c3_s   = SUM_W'($signed(row[3*COORD_W-1:2*COORD_W])) <<< 1;
      sx_pos = corner[0] ^ corner[1];
      sy_pos = corner[1];
      // exact sum at one extra fraction bit, plus one for round half up
      sum_s  = c3_s + (sx_pos ? c0_s : -c0_s) + (sy_pos ? c1_s : -c1_s)
               + SUM_W'(1);
      half   = sum_s[SUM_W-1:1];
      // saturate when the top bits disagree
      if (half[SUM_W-2:COORD_W-1] == '0 || half[SUM_W-2:COORD_W-1] == '1) begin
         coord_in = half[COORD_W-1:0];
      end else if (half[SUM_W-2]) begin
         coord_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         coord_in = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
   end

endmodule

[hw/rtl/quad_batch_vertex_generator.sv]
// draw: compares against each bound slot, binds a new handle when none matches, with a flush
// ahead of the bind when all slots are in use; one coordinate adder is shared by all twelve
// coordinates, each corner computing x, y and z and then emitting its vertex, and the slot
// search reads an entry and then compares it. one transaction at a time.
// reset is synchronous: empty batch, slot 1 next, limit 16384; the slot memory
// is not cleared and is only compared below the slots in use.
module quad_batch_vertex_generator import qbvg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   qbvg_req_if.sink           req_bus,
   qbvg_rsp_if.source         rsp_bus
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_END_FLUSH,
      ST_LIMIT_FLUSH,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SLOT_FLUSH,
      ST_BIND,
      ST_CALC,
      ST_VERT
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [ROW_W-1:0]     row_x_ff, row_x_in;
   logic [ROW_W-1:0]     row_y_ff, row_y_in;
   logic [ROW_W-1:0]     row_z_ff, row_z_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic [TILING_W-1:0]  tiling_ff, tiling_in;
   logic [ENTITY_W-1:0]  entity_ff, entity_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [INDEX_W-1:0]   index_count_ff, index_count_in;
   logic [USED_W-1:0]    slots_used_ff, slots_used_in;
   logic [USED_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [1:0]           ridx_ff, ridx_in;
   logic [1:0]           corner_ff, corner_in;
   logic [COORD_W-1:0]   pos_x_ff, pos_x_in;
   logic [COORD_W-1:0]   pos_y_ff, pos_y_in;
   logic [COORD_W-1:0]   pos_z_ff, pos_z_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   slot_wr_type          slot_wr;
   logic [HANDLE_W-1:0]  slot_rd_data;
   logic [ROW_W-1:0]     calc_row;
   logic [COORD_W-1:0]   coord;
   logic [LIMIT_W-1:0]   lim;
   logic [INDEX_W-1:0]   lim6;
   logic                 out_free;

   qbvg_slot_table u_slot_table (
      .clock      (clock),
      .wr         (slot_wr),
      .rd_addr    (scan_idx_ff[SLOT_W-1:0]),
      .rd_data_ff (slot_rd_data)
   );

   qbvg_coord_unit u_coord_unit (
      .clock    (clock),
      .row      (calc_row),
      .corner   (corner_ff),
      .coord_ff (coord)
   );

   always_comb begin
      if (limit_ff == '0) begin
         lim = LIMIT_W'(1);
      end else if (limit_ff > LIMIT_RESET) begin
         lim = LIMIT_RESET;
      end else begin
         lim = limit_ff;
      end
      lim6 = (INDEX_W'(lim) << 2) + (INDEX_W'(lim) << 1);
   end

   always_comb begin
      case (ridx_ff)
         2'd0:    calc_row = row_x_ff;
         2'd1:    calc_row = row_y_ff;
         default: calc_row = row_z_ff;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      row_x_in       = row_x_ff;
      row_y_in       = row_y_ff;
      row_z_in       = row_z_ff;
      color_in       = color_ff;
      handle_in      = handle_ff;
      tiling_in      = tiling_ff;
      entity_in      = entity_ff;
      limit_in       = limit_ff;
      index_count_in = index_count_ff;
      slots_used_in  = slots_used_ff;
      scan_idx_in    = scan_idx_ff;
      slot_in        = slot_ff;
      ridx_in        = ridx_ff;
      corner_in      = corner_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      pos_z_in       = pos_z_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      slot_wr        = '0;

      if (csr_we) begin
         limit_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               cmd_in    = req_bus.cmd;
               row_x_in  = req_bus.row_x;
               row_y_in  = req_bus.row_y;
               row_z_in  = req_bus.row_z;
               color_in  = req_bus.quad_color;
               handle_in = req_bus.texture_handle;
               tiling_in = req_bus.tiling_factor;
               entity_in = req_bus.entity_tag;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            scan_idx_in = USED_W'(1);
            case (cmd_ff)
               CMD_BEGIN: begin
                  index_count_in = '0;
                  slots_used_in  = USED_W'(1);
                  state_in       = ST_IDLE;
               end
               CMD_END: begin
                  state_in = (index_count_ff != '0) ? ST_END_FLUSH : ST_IDLE;
               end
               CMD_DRAW: begin
                  state_in = (index_count_ff >= lim6) ? ST_LIMIT_FLUSH : ST_SCAN_RD;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_END_FLUSH: begin
            if (out_free) begin
               rsp_in               = '0;
               rsp_in.kind          = KIND_FLUSH;
               rsp_in.batch_indices = index_count_ff;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_LIMIT_FLUSH, ST_SLOT_FLUSH: begin
            if (out_free || index_count_ff == '0) begin
               if (index_count_ff != '0) begin
                  rsp_in               = '0;
                  rsp_in.kind          = KIND_FLUSH;
                  rsp_in.batch_indices = index_count_ff;
                  rsp_valid_in         = 1'b1;
               end
               index_count_in = '0;
               slots_used_in  = USED_W'(1);
               state_in       = (state_ff == ST_SLOT_FLUSH) ? ST_BIND : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (scan_idx_ff >= slots_used_ff) begin
               state_in = (slots_used_ff >= USED_W'(SLOT_COUNT)) ? ST_SLOT_FLUSH : ST_BIND;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (slot_rd_data == handle_ff) begin
               slot_in   = scan_idx_ff[SLOT_W-1:0];
               ridx_in   = '0;
               corner_in = '0;
               state_in  = ST_CALC;
            end else begin
               scan_idx_in = scan_idx_ff + USED_W'(1);
               state_in    = ST_SCAN_RD;
            end
         end
         ST_BIND: begin
            if (out_free) begin
               slot_wr.en          = 1'b1;
               slot_wr.addr        = slots_used_ff[SLOT_W-1:0];
               slot_wr.data        = handle_ff;
               slot_in             = slots_used_ff[SLOT_W-1:0];
               slots_used_in       = slots_used_ff + USED_W'(1);
               rsp_in              = '0;
               rsp_in.kind         = KIND_BIND;
               rsp_in.slot_number  = slots_used_ff[SLOT_W-1:0];
               rsp_in.bound_handle = handle_ff;
               rsp_valid_in        = 1'b1;
               ridx_in             = '0;
               corner_in           = '0;
               state_in            = ST_CALC;
            end
         end
         ST_CALC: begin
            // adder result is registered and arrives in the cycle after its row is selected
            case (ridx_ff)
               2'd1:    pos_x_in = coord;
               2'd2:    pos_y_in = coord;
               2'd3:    pos_z_in = coord;
               default: ;
            endcase
            if (ridx_ff == 2'd3) begin
               state_in = ST_VERT;
            end else begin
               ridx_in = ridx_ff + 2'd1;
            end
         end
         ST_VERT: begin
            if (out_free) begin
               rsp_in               = '0;
               rsp_in.kind          = KIND_VERTEX;
               rsp_in.corner        = corner_ff;
               rsp_in.pos_x         = pos_x_ff;
               rsp_in.pos_y         = pos_y_ff;
               rsp_in.pos_z         = pos_z_ff;
               rsp_in.vertex_color  = color_ff;
               rsp_in.slot_number   = slot_ff;
               rsp_in.vertex_tiling = tiling_ff;
               rsp_in.vertex_entity = entity_ff;
               rsp_in.last          = (corner_ff == 2'd3);
               rsp_valid_in         = 1'b1;
               if (corner_ff == 2'd3) begin
                  index_count_in = index_count_ff + INDEX_W'(QUAD_INDICES);
                  state_in       = ST_IDLE;
               end else begin
                  corner_in = corner_ff + 2'd1;
                  ridx_in   = '0;
                  state_in  = ST_CALC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         limit_ff       <= LIMIT_RESET;
         index_count_ff <= '0;
         slots_used_ff  <= USED_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         limit_ff       <= limit_in;
         index_count_ff <= index_count_in;
         slots_used_ff  <= slots_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      row_x_ff    <= row_x_in;
      row_y_ff    <= row_y_in;
      row_z_ff    <= row_z_in;
      color_ff    <= color_in;
      handle_ff   <= handle_in;
      tiling_ff   <= tiling_in;
      entity_ff   <= entity_in;
      scan_idx_ff <= scan_idx_in;
      slot_ff     <= slot_in;
      ridx_ff     <= ridx_in;
      corner_ff   <= corner_in;
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      pos_z_ff    <= pos_z_in;
      rsp_ff      <= rsp_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_ff.kind;
   assign rsp_bus.corner        = rsp_ff.corner;
   assign rsp_bus.pos_x         = $signed(rsp_ff.pos_x);
   assign rsp_bus.pos_y         = $signed(rsp_ff.pos_y);
   assign rsp_bus.pos_z         = $signed(rsp_ff.pos_z);
   assign rsp_bus.vertex_color  = rsp_ff.vertex_color;
   assign rsp_bus.slot_number   = rsp_ff.slot_number;
   assign rsp_bus.bound_handle  = rsp_ff.bound_handle;
   assign rsp_bus.vertex_tiling = rsp_ff.vertex_tiling;
   assign rsp_bus.vertex_entity = $signed(rsp_ff.vertex_entity);
   assign rsp_bus.batch_indices = rsp_ff.batch_indices;
   assign rsp_bus.last          = rsp_ff.last;

endmodule

[hw/rtl/qbvg_checker.sv]
module qbvg_checker import qbvg_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic [1:0]          rsp_kind,
   input logic [HANDLE_W-1:0] rsp_bound_handle,
   input logic [INDEX_W-1:0]  rsp_batch_indices,
   input logic                rsp_last
);

   // output register empties on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // no new transaction while a transaction's results are still pending
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready with results still pending");

   a_bind_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BIND |-> !rsp_last)
      else $error("slot bind ended a transaction");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FLUSH |-> rsp_batch_indices != '0)
      else $error("empty batch flushed");

   a_vertex_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_VERTEX |->
         rsp_bound_handle == '0 && rsp_batch_indices == '0)
      else $error("vertex carries bind or flush fields");

endmodule

bind quad_batch_vertex_generator qbvg_checker u_qbvg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_kind          (rsp_bus.kind),
   .rsp_bound_handle  (rsp_bus.bound_handle),
   .rsp_batch_indices (rsp_bus.batch_indices),
   .rsp_last          (rsp_bus.last)
);
